FILE: rtl/srr_pkg.sv
// Shared types and constants of the selective-repeat receiver.
package srr_pkg;

    // Width of the sequence number field as it arrives on the wire.
    localparam int SEQ_NUM_W = 4;
    // Width of the acknowledged sequence number in a result.
    localparam int ACK_NUM_W = 4;
    // Number of distinct values that the wire sequence number can take.
    localparam int SEQ_NUM_VALS = 1 << SEQ_NUM_W;

    // Result kinds.
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Classification of one packet against the receive window.
    typedef struct packed {
        logic buffer;   // inside the receive window: store, ACK and deliver
        logic reack;    // inside the previous window: ACK only
    } t_verdict;

endpackage

FILE: rtl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver: window control, slot bookkeeping and result output.
//
// Usage: packets enter on the input channel (i_valid, o_stall) with a sequence
// number, a payload word and a checksum flag computed upstream. Results leave on
// the output channel (o_valid, i_stall); o_kind tells an acknowledgement from a
// payload delivered upward, and o_last marks the final result of one packet.
// A packet with a bad checksum, or one outside both the receive window and the
// previous window, produces no result and leaves the state untouched.
// A packet in the receive window is written to the slot memory, acknowledged,
// and then every buffered payload that is now in order is delivered, one per
// cycle, by reading the slot memory at the window head.
// Timing: a transaction on the input is followed by the evaluation state S_EVAL;
// the acknowledgement is registered into the output from S_ACK, and each delivery
// from S_DELIV out of the registered read data of the slot memory. A dropped
// packet frees the block after S_EVAL, an acknowledged one after S_ACK, and one
// releasing payloads (at most WINDOW_SIZE) after S_DELIV; the single read port
// of the slot memory sets the pace of one delivery per cycle unless the output stalls.
// o_stall is high while a packet is being worked on. A stall on the output
// holds the current result in the output register and pauses the delivery walk.
// Reset clears the window base, the window head and all slot-full bits at once;
// the block accepts a packet in the first cycle after reset.
module selective_repeat_receiver
    import srr_pkg::*;
#(
    parameter int WINDOW_SIZE  = 8,
    parameter int SEQ_SPACE    = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Packet input channel.
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SEQ_NUM_W-1:0]    i_seq_num,
    input  logic [PAYLOAD_BITS-1:0] i_payload_word,
    input  logic                    i_checksum_ok,
    // Result output channel.
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_kind,
    output logic [ACK_NUM_W-1:0]    o_ack_num,
    output logic [PAYLOAD_BITS-1:0] o_delivered_payload,
    output logic                    o_last
);

    localparam int SEQ_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_ACK,
        S_DELIV
    } t_state;

    // Control registers.
    t_state                  r_state, n_state;
    logic [SEQ_W-1:0]        r_base, n_base;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [WINDOW_SIZE-1:0]  r_full, n_full;
    logic                    r_buffered, n_buffered;
    logic                    r_out_valid, n_out_valid;

    // Payload registers.
    logic [SEQ_NUM_W-1:0]    r_seq_raw;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic                    r_ok;
    logic                    r_kind, n_kind;
    logic [ACK_NUM_W-1:0]    r_ack_num, n_ack_num;
    logic [PAYLOAD_BITS-1:0] r_out_pay, n_out_pay;
    logic                    r_last, n_last;

    logic                    in_accept;
    logic                    out_free;
    logic [SEQ_W-1:0]        seq;
    logic [SEQ_W-1:0]        ahead;
    t_verdict                verdict;
    logic [IDX_W:0]          slot_sum;
    logic [IDX_W-1:0]        slot;
    logic [IDX_W-1:0]        head_inc;
    logic [SEQ_W-1:0]        base_inc;
    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [PAYLOAD_BITS-1:0] ram_rd_data;

    assign in_accept = i_valid && !o_stall;
    // The output register can take a new result when empty or being taken now.
    assign out_free  = !r_out_valid || !i_stall;

    srr_window_check #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SEQ_SPACE   (SEQ_SPACE),
        .SEQ_W       (SEQ_W)
    ) u_window_check (
        .i_seq_raw (r_seq_raw),
        .i_base    (r_base),
        .o_seq     (seq),
        .o_ahead   (ahead),
        .o_verdict (verdict)
    );

    // Physical slot of a window offset: the head rotates instead of shifting slots.
    assign slot_sum = (IDX_W+1)'(r_head) + (IDX_W+1)'(ahead);
    assign slot     = (slot_sum >= (IDX_W+1)'(WINDOW_SIZE))
                    ? IDX_W'(slot_sum - (IDX_W+1)'(WINDOW_SIZE)) : IDX_W'(slot_sum);

    assign head_inc = (r_head == IDX_W'(WINDOW_SIZE - 1)) ? '0 : r_head + 1'b1;
    assign base_inc = (r_base == SEQ_W'(SEQ_SPACE - 1)) ? '0 : r_base + 1'b1;

    srr_slot_ram #(
        .DEPTH  (WINDOW_SIZE),
        .WIDTH  (PAYLOAD_BITS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (slot),
        .i_wr_data (r_pay),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_head      = r_head;
        n_full      = r_full;
        n_buffered  = r_buffered;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_ack_num   = r_ack_num;
        n_out_pay   = r_out_pay;
        n_last      = r_last;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_ok && verdict.buffer) begin
                    // Store the payload; an already buffered slot is simply overwritten.
                    ram_wr_en    = 1'b1;
                    n_full[slot] = 1'b1;
                    n_buffered   = 1'b1;
                    n_state      = S_ACK;
                end else if (r_ok && verdict.reack) begin
                    n_buffered = 1'b0;
                    n_state    = S_ACK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ACK;
                    n_ack_num   = ACK_NUM_W'(seq);
                    n_out_pay   = '0;
                    n_last      = !(r_buffered && r_full[r_head]);
                    if (r_buffered && r_full[r_head]) begin
                        // Start the delivery walk at the window head.
                        ram_rd_en      = 1'b1;
                        n_full[r_head] = 1'b0;
                        n_head         = head_inc;
                        n_base         = base_inc;
                        n_state        = S_DELIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DELIV: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DATA;
                    n_ack_num   = '0;
                    n_out_pay   = ram_rd_data;
                    // Slots are cleared as they are read, so the walk ends within one window.
                    n_last      = !r_full[r_head];
                    if (r_full[r_head]) begin
                        ram_rd_en      = 1'b1;
                        n_full[r_head] = 1'b0;
                        n_head         = head_inc;
                        n_base         = base_inc;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_head      <= '0;
            r_full      <= '0;
            r_buffered  <= 1'b0;
            r_out_valid <= 1'b0;
            r_kind      <= KIND_ACK;
            r_ack_num   <= '0;
            r_out_pay   <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_head      <= n_head;
            r_full      <= n_full;
            r_buffered  <= n_buffered;
            r_out_valid <= n_out_valid;
            r_kind      <= n_kind;
            r_ack_num   <= n_ack_num;
            r_out_pay   <= n_out_pay;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_seq_raw <= i_seq_num;
            r_pay     <= i_payload_word;
            r_ok      <= i_checksum_ok;
        end
    end

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_kind              = r_kind;
    assign o_ack_num           = r_ack_num;
    assign o_delivered_payload = r_out_pay;
    assign o_last              = r_last;

    // The window base only moves while the delivery walk reads a slot.
    a_base_moves_on_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ACK && r_state != S_DELIV) |=> $stable(r_base))
        else $error("window base moved outside the delivery walk");

    // The slot memory is never written and read in the same cycle.
    a_ram_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("slot memory written and read in the same cycle");

    // Every slot read by the walk holds a buffered payload.
    a_read_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_rd_en |-> r_full[r_head])
        else $error("delivery read an empty slot");

endmodule

FILE: rtl/srr_slot_ram.sv
// Payload slot memory: one write port and one read port with registered read data.
module srr_slot_ram
    import srr_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/srr_window_check.sv
// Sequence number reduction and receive window classification.
module srr_window_check
    import srr_pkg::*;
#(
    parameter int WINDOW_SIZE = 8,
    parameter int SEQ_SPACE   = 16,
    parameter int SEQ_W       = 4
) (
    input  logic [SEQ_NUM_W-1:0] i_seq_raw,
    input  logic [SEQ_W-1:0]     i_base,
    output logic [SEQ_W-1:0]     o_seq,
    output logic [SEQ_W-1:0]     o_ahead,
    output t_verdict             o_verdict
);

    // Reduction of the wire sequence number into the sequence space.
    logic [SEQ_W-1:0] red_tbl [SEQ_NUM_VALS];

    for (genvar v = 0; v < SEQ_NUM_VALS; v++) begin : g_red
        localparam int RED = v % SEQ_SPACE;
        assign red_tbl[v] = SEQ_W'(RED);
    end

    logic [SEQ_W:0] ahead_raw;
    logic [SEQ_W:0] behind_raw;
    logic [SEQ_W-1:0] behind;

    assign o_seq = red_tbl[i_seq_raw];

    // Both distances lie in [1, 2*SEQ_SPACE), so one conditional subtract wraps them.
    assign ahead_raw  = (SEQ_W+1)'(o_seq) + (SEQ_W+1)'(SEQ_SPACE) - (SEQ_W+1)'(i_base);
    assign behind_raw = (SEQ_W+1)'(i_base) + (SEQ_W+1)'(SEQ_SPACE) - (SEQ_W+1)'(o_seq);

    assign o_ahead = (ahead_raw >= (SEQ_W+1)'(SEQ_SPACE))
                   ? SEQ_W'(ahead_raw - (SEQ_W+1)'(SEQ_SPACE)) : SEQ_W'(ahead_raw);
    assign behind  = (behind_raw >= (SEQ_W+1)'(SEQ_SPACE))
                   ? SEQ_W'(behind_raw - (SEQ_W+1)'(SEQ_SPACE)) : SEQ_W'(behind_raw);

    // The receive window test takes priority over the previous window test.
    assign o_verdict.buffer = (32'(o_ahead) < 32'(WINDOW_SIZE));
    assign o_verdict.reack  = !o_verdict.buffer && (behind != '0)
                            && (32'(behind) <= 32'(WINDOW_SIZE));

endmodule

FILE: bench/selective_repeat_receiver_tb.sv
// Self-checking testbench for the selective-repeat ARQ receiver.
`timescale 1ns / 100ps

// Tracks the receive window as the block should see it and holds the results that each
// accepted packet must produce, in the order they must leave the block.
class arq_window_scoreboard;
    localparam int WIN = 8;

    typedef struct {
        logic       kind;
        logic [3:0] ack_num;
        logic [31:0] payload;
        logic       last;
    } t_arq_result;

    logic [3:0]  win_base;
    logic        slot_full [WIN];
    logic [31:0] slot_data [WIN];
    t_arq_result pending_q [$];
    int          failures;

    function new();
        win_base = '0;
        failures = 0;
        foreach (slot_full[i]) begin
            slot_full[i] = 1'b0;
            slot_data[i] = '0;
        end
    endfunction

    function void push_result(logic kind, logic [3:0] ack, logic [31:0] pay);
        t_arq_result r;
        r.kind    = kind;
        r.ack_num = ack;
        r.payload = pay;
        r.last    = 1'b0;
        pending_q.push_back(r);
    endfunction

    // Called for every packet transaction the block accepts.
    function void note_packet(logic [3:0] seq, logic [31:0] pay, logic ok);
        logic [3:0] ahead;
        logic [3:0] behind;
        int         run;
        if (!ok) return;
        ahead  = seq - win_base;
        behind = win_base - seq;
        if (ahead < WIN) begin
            slot_full[ahead] = 1'b1;
            slot_data[ahead] = pay;
            push_result(srr_pkg::KIND_ACK, seq, '0);
            run = 0;
            while (run < WIN && slot_full[run]) begin
                push_result(srr_pkg::KIND_DATA, '0, slot_data[run]);
                run++;
            end
            for (int i = 0; i < WIN; i++) begin
                if (i + run < WIN) begin
                    slot_full[i] = slot_full[i + run];
                    slot_data[i] = slot_data[i + run];
                end else begin
                    slot_full[i] = 1'b0;
                end
            end
            win_base = win_base + 4'(run);
        end else if (behind >= 1 && behind <= WIN) begin
            push_result(srr_pkg::KIND_ACK, seq, '0);
        end else begin
            return;
        end
        pending_q[pending_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        failures++;
    endtask

    // Called for every result transaction the block hands out.
    task check_result(logic kind, logic [3:0] ack, logic [31:0] pay, logic last);
        t_arq_result exp_r;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result kind=%0d ack=%0d data=%h last=%0d",
                             kind, ack, pay, last));
            return;
        end
        exp_r = pending_q.pop_front();
        if (kind !== exp_r.kind)
            report($sformatf("kind %0d, expected %0d", kind, exp_r.kind));
        if (ack !== exp_r.ack_num)
            report($sformatf("ack_num %0d, expected %0d", ack, exp_r.ack_num));
        if (pay !== exp_r.payload)
            report($sformatf("delivered_payload %h, expected %h", pay, exp_r.payload));
        if (last !== exp_r.last)
            report($sformatf("last %0d, expected %0d", last, exp_r.last));
    endtask
endclass

module selective_repeat_receiver_tb;
    import srr_pkg::*;

    localparam int WINDOW_SIZE  = 8;
    localparam int SEQ_SPACE    = 16;
    localparam int PAYLOAD_BITS = 32;
    // Number of in-window packets after which the random part starts no new group; stray packets are not counted.
    localparam int RANDOM_PACKETS = 210;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [SEQ_NUM_W-1:0]    i_seq_num = '0;
    logic [PAYLOAD_BITS-1:0] i_payload_word = '0;
    logic                    i_checksum_ok = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_kind;
    logic [ACK_NUM_W-1:0]    o_ack_num;
    logic [PAYLOAD_BITS-1:0] o_delivered_payload;
    logic                    o_last;

    // When cleared, neither the packet source nor the result sink inserts bubbles.
    bit idle_on = 1'b1;

    arq_window_scoreboard sb = new();

    selective_repeat_receiver #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SEQ_SPACE   (SEQ_SPACE),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_seq_num          (i_seq_num),
        .i_payload_word     (i_payload_word),
        .i_checksum_ok      (i_checksum_ok),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_kind             (o_kind),
        .o_ack_num          (o_ack_num),
        .o_delivered_payload(o_delivered_payload),
        .o_last             (o_last)
    );

    always #4 i_clk = ~i_clk;

    // The result sink holds off about a quarter of the cycles while idling is allowed.
    // It changes only on the falling edge, so the block sees a settled stall at the
    // rising edge.
    always @(negedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(0, 99) < 25);
    end

    // Both channels are sampled at the rising edge. Inputs only move on the falling
    // edge, and the block's outputs still hold their pre-edge values here, so the
    // handshake seen here is the one the block sees.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_packet(i_seq_num, i_payload_word, i_checksum_ok);
            if (o_valid && !i_stall)
                sb.check_result(o_kind, o_ack_num, o_delivered_payload, o_last);
        end
    end

    // Offers one packet and returns once the block has taken it. Valid stays high
    // after the transaction; the next call either drives a new packet over it or
    // drops it for a bubble, so i_valid is written once per falling edge at most.
    task automatic send_packet(input logic [SEQ_NUM_W-1:0] seq,
                               input logic [PAYLOAD_BITS-1:0] word,
                               input logic ok);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_seq_num      <= seq;
        i_payload_word <= word;
        i_checksum_ok  <= ok;
        do @(posedge i_clk); while (o_stall);
    endtask

    // One stray packet between in-window traffic: a corrupted packet, a retransmission
    // from the previous window, or a fully random sequence number.
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 2);
        case (pick)
            0: begin
                send_packet(4'($urandom), $urandom, 1'b0);
            end
            1: begin
                send_packet(sb.win_base - 4'($urandom_range(1, WINDOW_SIZE)), $urandom, 1'b1);
            end
            default: begin
                send_packet(4'($urandom), $urandom, 1'b1);
            end
        endcase
    endtask

    initial begin
        logic [SEQ_NUM_W-1:0] grp_base;
        int                   order [WINDOW_SIZE];
        int                   grp_len;
        int                   j;
        int                   tmp;
        int                   sent;
        int                   waited;

        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The window starts at 0 and covers 0..7.
        // A corrupted packet is dropped without any result.
        send_packet(4'd0, 32'hFFFF_FFFF, 1'b0);
        // In-order arrival at the window head: ACK plus one delivery, base moves to 1.
        send_packet(4'd0, 32'h0000_0000, 1'b1);
        // Sequence 0 now sits just behind the window: re-ACK only.
        send_packet(4'd0, 32'hFFFF_FFFF, 1'b1);
        // Out of order: buffered and ACKed, nothing delivered yet.
        send_packet(4'd2, 32'hFFFF_FFFF, 1'b1);
        // Same slot again: the payload is overwritten and ACKed once more.
        send_packet(4'd2, 32'h1234_5678, 1'b1);
        // Far edge of the receive window (offset WINDOW_SIZE-1).
        send_packet(4'd8, 32'hA5A5_5A5A, 1'b1);
        // One past the window, which is the far edge of the previous window: re-ACK.
        send_packet(4'd9, 32'h5A5A_A5A5, 1'b1);
        // Fills the gap: delivers 1 and the overwritten 2, base moves to 3.
        send_packet(4'd1, $urandom, 1'b1);
        // Fill the other slots of window 3..10 (8 is already buffered), then the head
        // releases all eight payloads at once, with wraparound of the window on the way to base 11.
        send_packet(4'd4, $urandom, 1'b1);
        send_packet(4'd5, $urandom, 1'b1);
        send_packet(4'd6, $urandom, 1'b1);
        send_packet(4'd7, $urandom, 1'b1);
        send_packet(4'd9, $urandom, 1'b1);
        send_packet(4'd10, $urandom, 1'b1);
        send_packet(4'd3, $urandom, 1'b1);
        // Window now 11..2 across the wrap of the sequence space.
        send_packet(4'd15, 32'hFFFF_FFFF, 1'b0);
        send_packet(4'd15, 32'h8000_0001, 1'b1);
        send_packet(4'd3, 32'h7FFF_FFFE, 1'b1);

        // Random part: windows are filled in shuffled order, so the head arrives at a
        // random point and releases runs of every length, with stray packets mixed in.
        sent = 0;
        while (sent < RANDOM_PACKETS) begin
            // The scoreboard has seen the last transaction once the falling edge is here.
            @(negedge i_clk);
            // A long middle stretch runs with both sides at full rate.
            idle_on = !(sent >= 100 && sent < 160);
            grp_base = sb.win_base;
            grp_len  = $urandom_range(1, WINDOW_SIZE);
            for (int i = 0; i < grp_len; i++)
                order[i] = i;
            for (int i = grp_len - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < grp_len; i++) begin
                if ($urandom_range(0, 99) < 15)
                    send_noise();
                send_packet(grp_base + 4'(order[i]), $urandom, 1'b1);
                sent++;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        idle_on = 1'b1;

        // Drain whatever is still due, then give the block time to show any
        // result it should not produce.
        waited = 0;
        while (sb.pending_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending_q.size()));
        repeat (4 * (WINDOW_SIZE + 4)) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
